// ----- rtl/mcb_pkg.sv -----
// Shared constants, state codes and helper functions for the monotone cubic
// to Bezier converter. No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mcb_pkg;

  // Field widths of the knot and point words.
  localparam int X_BITS  = 16;
  localparam int Y_BITS  = 16;
  localparam int NUM_W   = 51;   // slope numerator and denominator width
  localparam int MA_W    = 36;   // shared multiplier, A operand (signed)
  localparam int MB_W    = 17;   // shared multiplier, B operand (signed)
  localparam int MP_W    = MA_W + MB_W;
  localparam int D3_W    = 29;   // signed operand of the divide-by-three unit
  localparam int SLOPE_W = 32;

  // Point kinds.
  localparam logic [1:0] KIND_KNOT = 2'd0;
  localparam logic [1:0] KIND_H1   = 2'd1;
  localparam logic [1:0] KIND_H2   = 2'd2;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_SMUL  = 11'b000_0000_0010,
    S_SDIV  = 11'b000_0000_0100,
    S_KNOT  = 11'b000_0000_1000,
    S_HXS   = 11'b000_0001_0000,
    S_HXW   = 11'b000_0010_0000,
    S_HMUL  = 11'b000_0100_0000,
    S_HYS   = 11'b000_1000_0000,
    S_HYW   = 11'b001_0000_0000,
    S_HEMIT = 11'b010_0000_0000,
    S_FINAL = 11'b100_0000_0000
  } state_t;

  // Clamp a signed sum to the unsigned x range.
  function automatic logic [X_BITS-1:0] clamp_x(input logic signed [29:0] v);
    logic [X_BITS-1:0] r;
    if (v < 0) r = '0;
    else if (v > 30'sd65535) r = '1;
    else r = v[X_BITS-1:0];
    return r;
  endfunction

  // Saturate a signed sum to the signed y range.
  function automatic logic signed [Y_BITS-1:0] sat_y(input logic signed [29:0] v);
    logic signed [Y_BITS-1:0] r;
    if (v > 30'sd32767) r = 16'sh7FFF;
    else if (v < -30'sd32768) r = 16'sh8000;
    else r = v[Y_BITS-1:0];
    return r;
  endfunction

  // Seven radix-4 digits of a long division by three; returns {rem, quotient}.
  function automatic logic [15:0] div3_chunk(input logic [1:0] rin,
                                             input logic [13:0] d);
    logic [1:0]  r;
    logic [3:0]  t;
    logic [13:0] q;
    r = rin;
    q = '0;
    for (int i = 6; i >= 0; i--) begin
      t = {r, d[2*i+1 -: 2]};
      if (t >= 4'd9) begin
        q[2*i+1 -: 2] = 2'd3;
        t = t - 4'd9;
      end else if (t >= 4'd6) begin
        q[2*i+1 -: 2] = 2'd2;
        t = t - 4'd6;
      end else if (t >= 4'd3) begin
        q[2*i+1 -: 2] = 2'd1;
        t = t - 4'd3;
      end else begin
        q[2*i+1 -: 2] = 2'd0;
      end
      r = t[1:0];
    end
    return {r, q};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mcb_if.sv -----
// Valid/ready channel interfaces for knot words in and point words out.
// Depends on mcb_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface knot_if import mcb_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [X_BITS-1:0]        knot_x;
  logic signed [Y_BITS-1:0] knot_y;
  logic                     final_knot;

  modport source (output valid, knot_x, knot_y, final_knot, input ready);
  modport sink   (input valid, knot_x, knot_y, final_knot, output ready);
endinterface

interface point_if import mcb_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [X_BITS-1:0]        point_x;
  logic signed [Y_BITS-1:0] point_y;
  logic [1:0]               point_kind;
  logic                     curve_end;
  logic                     run_last;

  modport source (output valid, point_x, point_y, point_kind, curve_end, run_last,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_kind, curve_end, run_last,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/mcb_div3.sv -----
// Signed floor division by three, seven radix-4 digits per cycle.
// Depends on mcb_pkg (div3_chunk, D3_W). Result is valid when done pulses.
`timescale 1ns / 1ps
`default_nettype none

module mcb_div3 import mcb_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic signed [D3_W-1:0] val,
  output logic                        done,
  output logic signed [D3_W-1:0]      quot
);

  logic [27:0] mag;
  logic [27:0] q;
  logic [1:0]  rem;
  logic        neg;
  logic        step;
  logic        busy;
  logic [15:0] chunk;
  logic signed [D3_W-1:0] qext;

  // One chunk of digits, high half first.
  assign chunk = div3_chunk(rem, step ? mag[13:0] : mag[27:14]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 1'b0;
      end else if (busy) begin
        step <= 1'b1;
        if (step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: magnitude, remainder and quotient digits.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= val[D3_W-1];
      mag <= val[D3_W-1] ? 28'(-val) : val[27:0];
      rem <= 2'd0;
    end else if (busy) begin
      rem <= chunk[15:14];
      q   <= {q[13:0], chunk[13:0]};
    end
  end

  // Floor for negative operands rounds the magnitude up.
  assign qext = D3_W'(signed'({1'b0, q}));
  assign quot = neg ? -(qext + D3_W'(rem != 2'd0)) : qext;

endmodule

`default_nettype wire

// ----- rtl/mcb_sdiv.sv -----
// Restoring divider for the slope: 32 quotient bits of num * 2^20 / den.
// Depends on mcb_pkg (NUM_W). Flags overflow of the 32-bit quotient.
`timescale 1ns / 1ps
`default_nettype none

module mcb_sdiv import mcb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [NUM_W-1:0] den,
  output logic                  done,
  output logic                  ovf,
  output logic [SLOPE_W-1:0]    mag
);

  logic [63:0] rem;
  logic [62:0] dbig;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] rsh;
  logic [63:0] diff;

  assign rsh  = {rem[62:0], 1'b0};
  assign diff = rsh - {1'b0, dbig};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // One compare and subtract per cycle against den shifted up by twelve.
  always_ff @(posedge clk) begin
    if (start) begin
      dbig <= {den, 12'b0};
      rem  <= {13'b0, num};
      ovf  <= ({12'b0, num} >= {den, 12'b0});
    end else if (busy) begin
      if (!diff[63]) begin
        rem <= diff;
        mag <= {mag[SLOPE_W-2:0], 1'b1};
      end else begin
        rem <= rsh;
        mag <= {mag[SLOPE_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/monotone_cubic_to_bezier.sv -----
// Monotone cubic to Bezier converter. Knot words arrive in ascending x, the
// last one flagged; for every knot after the second the block forms the
// Fritsch-Carlson slope at the middle knot and sends the Bezier segment that
// starts at the older knot as three point words (knot, one-third handle,
// two-thirds handle). The final knot closes the curve with a segment of zero
// end slope and the knot itself, marked curve_end. A knot is taken only when
// the sequencer is idle. An interior knot is accepted, then its products are
// formed on the shared 36x17 multiplier, then the bit-serial slope division
// runs, and then its segment is sent, whose handles each wait on the
// divide-by-three unit twice. A final knot adds one more segment and the
// closing knot word.
// Depends on mcb_pkg, mcb_if, mcb_div3 and mcb_sdiv.
`timescale 1ns / 1ps
`default_nettype none

module monotone_cubic_to_bezier import mcb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  knot_if.sink      knot,
  point_if.source   point
);

  state_t state;
  logic [2:0] cnt;
  logic       hsel;
  logic       shift_pend;
  logic [1:0] seen;

  logic [X_BITS-1:0]        older_x, newer_x, cur_x, hx;
  logic signed [Y_BITS-1:0] older_y, newer_y, cur_y, hy;
  logic                     cur_fin;
  logic signed [SLOPE_W-1:0] carried_slope, slope_new;

  logic [NUM_W-1:0] num, den;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] mul_p;

  logic signed [16:0] h1, h2, dy1, dy2, xd;
  logic [15:0]        a1, a2;
  logic               slope_ok;
  logic signed [MP_W-1:0] ysum;

  logic                   d3_start, d3_done;
  logic signed [D3_W-1:0] d3_val, d3_q;
  logic                   sd_start, sd_done, sd_ovf;
  logic [SLOPE_W-1:0]     sd_mag;
  logic signed [SLOPE_W-1:0] slope_sat;

  logic out_free, out_load;
  logic [X_BITS-1:0]        ox;
  logic signed [Y_BITS-1:0] oy;
  logic [1:0]               okind;
  logic                     oend, olast;

  // Differences of the three-knot window.
  assign h1  = signed'({1'b0, newer_x}) - signed'({1'b0, older_x});
  assign h2  = signed'({1'b0, cur_x}) - signed'({1'b0, newer_x});
  assign dy1 = 17'(newer_y) - 17'(older_y);
  assign dy2 = 17'(cur_y) - 17'(newer_y);
  assign a1  = dy1[16] ? 16'(-dy1) : dy1[15:0];
  assign a2  = dy2[16] ? 16'(-dy2) : dy2[15:0];
  assign xd  = signed'({1'b0, newer_x}) - signed'({1'b0, older_x});
  assign slope_ok = !h1[16] && (h1 != 17'sd0) && !h2[16] && (h2 != 17'sd0) &&
                    (dy1 != 17'sd0) && (dy2 != 17'sd0) && (dy1[16] == dy2[16]);

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SMUL: begin
        case (cnt)
          3'd0: begin
            mul_a = MA_W'(3 * (h1[15:0] + h2[15:0]));
            mul_b = MB_W'(a1);
          end
          3'd1: begin
            mul_a = mul_p[MA_W-1:0];
            mul_b = MB_W'(a2);
          end
          3'd2: begin
            mul_a = MA_W'(2 * h2[15:0] + h1[15:0]);
            mul_b = MB_W'(h1[15:0]);
          end
          3'd3: begin
            mul_a = mul_p[MA_W-1:0];
            mul_b = MB_W'(a2);
          end
          3'd4: begin
            mul_a = MA_W'(h2[15:0] + 2 * h1[15:0]);
            mul_b = MB_W'(h2[15:0]);
          end
          3'd5: begin
            mul_a = mul_p[MA_W-1:0];
            mul_b = MB_W'(a1);
          end
          default: ;
        endcase
      end
      S_HMUL: begin
        mul_a = MA_W'(hsel ? slope_new : carried_slope);
        mul_b = xd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // Handle y offset before the divide by three, rounded half up.
  assign ysum = mul_p + MP_W'(3 << 19);

  // Divide-by-three operand: x handle offsets, or the y term.
  always_comb begin
    if (state == S_HYS) d3_val = ysum[48:20];
    else if (hsel) d3_val = D3_W'(2 * xd + 17'sd1);
    else d3_val = D3_W'(xd + 17'sd1);
  end
  assign d3_start = (state == S_HXS) || (state == S_HYS);
  assign sd_start = (state == S_SMUL) && (cnt == 3'd7);

  mcb_div3 u_div3 (
    .clk   (clk),
    .rst   (rst),
    .start (d3_start),
    .val   (d3_val),
    .done  (d3_done),
    .quot  (d3_q)
  );

  mcb_sdiv u_sdiv (
    .clk   (clk),
    .rst   (rst),
    .start (sd_start),
    .num   (num),
    .den   (den),
    .done  (sd_done),
    .ovf   (sd_ovf),
    .mag   (sd_mag)
  );

  // Signed saturation of the slope magnitude.
  always_comb begin
    if (!dy1[16]) begin
      slope_sat = (sd_ovf || sd_mag[31]) ? 32'sh7FFF_FFFF : signed'(sd_mag);
    end else if (sd_ovf || (sd_mag > 32'h8000_0000)) begin
      slope_sat = 32'sh8000_0000;
    end else begin
      slope_sat = -signed'(sd_mag);
    end
  end

  assign out_free = !point.valid || point.ready;
  assign knot.ready = (state == S_IDLE);

  // Sequencer and point-word selection.
  always_comb begin
    out_load = 1'b0;
    ox = older_x;
    oy = older_y;
    okind = KIND_KNOT;
    oend = 1'b0;
    olast = 1'b0;
    unique case (state)
      S_KNOT: out_load = out_free;
      S_HEMIT: begin
        out_load = out_free;
        ox = hx;
        oy = hy;
        okind = hsel ? KIND_H2 : KIND_H1;
        olast = hsel && shift_pend && !cur_fin;
      end
      S_FINAL: begin
        out_load = out_free;
        ox = cur_x;
        oy = cur_y;
        oend = 1'b1;
        olast = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      hsel <= 1'b0;
      shift_pend <= 1'b0;
      seen <= 2'd0;
      carried_slope <= '0;
      older_x <= '0;
      older_y <= '0;
      newer_x <= '0;
      newer_y <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (knot.valid) begin
            cur_x <= knot.knot_x;
            cur_y <= knot.knot_y;
            cur_fin <= knot.final_knot;
            shift_pend <= 1'b0;
            case (seen)
              2'd2: begin
                shift_pend <= 1'b1;
                cnt <= '0;
                state <= S_SMUL;
              end
              2'd1: begin
                newer_x <= knot.knot_x;
                newer_y <= knot.knot_y;
                if (knot.final_knot) begin
                  slope_new <= '0;
                  state <= S_KNOT;
                end else begin
                  seen <= 2'd2;
                end
              end
              default: begin
                if (knot.final_knot) begin
                  state <= S_FINAL;
                end else begin
                  older_x <= knot.knot_x;
                  older_y <= knot.knot_y;
                  seen <= 2'd1;
                end
              end
            endcase
          end
        end
        S_SMUL: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd0 && !slope_ok) begin
            slope_new <= '0;
            state <= S_KNOT;
          end
          if (cnt == 3'd2) num <= mul_p[NUM_W-1:0];
          if (cnt == 3'd4) den <= mul_p[NUM_W-1:0];
          if (cnt == 3'd6) den <= den + mul_p[NUM_W-1:0];
          if (cnt == 3'd7) state <= S_SDIV;
        end
        S_SDIV: begin
          if (sd_done) begin
            slope_new <= slope_sat;
            state <= S_KNOT;
          end
        end
        S_KNOT: begin
          if (out_free) begin
            hsel <= 1'b0;
            state <= S_HXS;
          end
        end
        S_HXS: state <= S_HXW;
        S_HXW: begin
          if (d3_done) begin
            hx <= clamp_x(30'(older_x) + 30'(d3_q));
            state <= S_HMUL;
          end
        end
        S_HMUL: state <= S_HYS;
        S_HYS: state <= S_HYW;
        S_HYW: begin
          if (d3_done) begin
            hy <= hsel ? sat_y(30'(newer_y) - 30'(d3_q))
                       : sat_y(30'(older_y) + 30'(d3_q));
            state <= S_HEMIT;
          end
        end
        S_HEMIT: begin
          if (out_free) begin
            if (!hsel) begin
              hsel <= 1'b1;
              state <= S_HXS;
            end else if (shift_pend) begin
              // Slide the window past the segment just sent.
              shift_pend <= 1'b0;
              older_x <= newer_x;
              older_y <= newer_y;
              newer_x <= cur_x;
              newer_y <= cur_y;
              carried_slope <= slope_new;
              if (cur_fin) begin
                slope_new <= '0;
                state <= S_KNOT;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              state <= S_FINAL;
            end
          end
        end
        S_FINAL: begin
          if (out_free) begin
            seen <= 2'd0;
            carried_slope <= '0;
            older_x <= '0;
            older_y <= '0;
            newer_x <= '0;
            newer_y <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      point.valid <= 1'b0;
    end else if (out_load) begin
      point.valid <= 1'b1;
    end else if (point.ready) begin
      point.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      point.point_x <= ox;
      point.point_y <= oy;
      point.point_kind <= okind;
      point.curve_end <= oend;
      point.run_last <= olast;
    end
  end

  // The window never counts past two knots.
  a_seen_range: assert property (@(posedge clk) disable iff (rst)
    seen != 2'd3) else $error("knot count out of range");

  // The curve end is always the last word of its knot.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.curve_end |-> point.run_last)
    else $error("curve end without run_last");

  // Sending the final knot empties the window.
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL) && out_free |=> (seen == 2'd0) && (carried_slope == '0))
    else $error("window not cleared after final knot");

  // A point word always carries one of the three defined kinds.
  a_kind_valid: assert property (@(posedge clk) disable iff (rst)
    point.valid |-> (point.point_kind == KIND_KNOT) || (point.point_kind == KIND_H1) ||
                    (point.point_kind == KIND_H2))
    else $error("bad point kind");

endmodule

`default_nettype wire
